// File: rtl/weighted_tag_best_match_assert.svh
// Assertion macros used by the checker file
`ifndef WEIGHTED_TAG_BEST_MATCH_ASSERT_SVH
`define WEIGHTED_TAG_BEST_MATCH_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define WTBM_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define WTBM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

// File: rtl/wtbm_pkg.sv
// Constants and types for the weighted tag best-match search
package wtbm_pkg;

  localparam int TYPE_COUNT  = 16;
  localparam int ASSET_DEPTH = 1024;
  localparam int TAG_DEPTH   = 4096;
  localparam int TAG_KINDS   = 8;

  localparam int TYPE_W  = $clog2(TYPE_COUNT);
  localparam int ASSET_W = $clog2(ASSET_DEPTH);
  localparam int TAG_W   = $clog2(TAG_DEPTH);
  localparam int KIND_W  = $clog2(TAG_KINDS);

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_TAG    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ASSET  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TYPE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VECTOR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AREQ  = 6'b000010,
    ST_AWAIT = 6'b000100,
    ST_TWALK = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [12:0] first_tag;
    logic [12:0] end_tag;
    logic [11:0] slot;
  } asset_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } tag_word_t;

endpackage

// File: rtl/weighted_tag_best_match.sv
// Weighted tag best-match search: table loading and query walk
// A write item is stored when it is accepted. A query reads each entry of the type's
//   range in turn; the single-port tag memory issues one tag read a cycle into a
//   read/multiply/accumulate pipeline, and each entry adds read, drain and compare steps.
// Throughput: one item at a time; the next item is taken once the query's result is
//   registered. Reset clears the type table, targets, weights and control; the entry
//   and tag memories hold no reset value and need no clearing pass.
module weighted_tag_best_match (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_type_id,
  input  logic [9:0]         in_asset_index,
  input  logic [10:0]        in_first_asset,
  input  logic [10:0]        in_end_asset,
  input  logic [12:0]        in_first_tag,
  input  logic [12:0]        in_end_tag,
  input  logic [11:0]        in_slot_id,
  input  logic [11:0]        in_tag_index,
  input  logic [2:0]         in_tag_kind,
  input  logic signed [31:0] in_value,
  input  logic [31:0]        in_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_best_slot,
  output logic               out_found
);

  localparam int AW = wtbm_pkg::ASSET_W;
  localparam int TW = wtbm_pkg::TAG_W;
  localparam int KW = wtbm_pkg::KIND_W;
  localparam int YW = wtbm_pkg::TYPE_W;

  wtbm_pkg::state_t state_r, state_nxt;

  logic [10:0] type_first_r [wtbm_pkg::TYPE_COUNT];
  logic [10:0] type_end_r   [wtbm_pkg::TYPE_COUNT];
  logic [31:0] target_r     [wtbm_pkg::TAG_KINDS];
  logic [31:0] weight_r     [wtbm_pkg::TAG_KINDS];

  wtbm_pkg::asset_word_t asset_mem [wtbm_pkg::ASSET_DEPTH];
  wtbm_pkg::tag_word_t   tag_mem   [wtbm_pkg::TAG_DEPTH];
  wtbm_pkg::asset_word_t asset_q_r;
  wtbm_pkg::tag_word_t   tag_q_r;

  logic        accept;
  logic [10:0] a_r, aend_r;
  logic [12:0] t_r, tend_r;
  logic [11:0] cur_slot_r, best_slot_r;
  logic [63:0] sum_r, best_r;
  logic        have_r;
  logic        v1_r, v2_r, v3_r;
  logic [32:0] mag_r;
  logic [31:0] wgt_r;
  logic [63:0] prod_r;
  logic        out_valid_r, out_found_r;
  logic [11:0] out_slot_r;

  logic        issue;
  logic        kind_ok;
  logic [KW-1:0] kind_idx;
  logic signed [32:0] diff;
  logic [32:0] mag_nxt;
  logic [63:0] prod_nxt;
  logic [64:0] sum_add;
  logic        walk_done;
  logic        out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != wtbm_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (state_r == wtbm_pkg::ST_TWALK) && (t_r < tend_r);
  assign walk_done = !issue && !v1_r && !v2_r && !v3_r;

  // Writes happen only in idle and reads only during a query, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (accept && in_mode == wtbm_pkg::MODE_ASSET &&
        32'(in_asset_index) < wtbm_pkg::ASSET_DEPTH) begin
      asset_mem[in_asset_index[AW-1:0]] <= '{in_first_tag, in_end_tag, in_slot_id};
    end
    if (state_r == wtbm_pkg::ST_AREQ) begin
      asset_q_r <= asset_mem[a_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode == wtbm_pkg::MODE_TAG &&
        32'(in_tag_index) < wtbm_pkg::TAG_DEPTH) begin
      tag_mem[in_tag_index[TW-1:0]] <= '{in_tag_kind, in_value};
    end
    if (issue) begin
      tag_q_r <= tag_mem[t_r[TW-1:0]];
    end
  end

  // Stage 1: distance to target
  assign kind_ok  = 32'(tag_q_r.kind) < wtbm_pkg::TAG_KINDS;
  assign kind_idx = tag_q_r.kind[KW-1:0];
  assign diff     = $signed({target_r[kind_idx][31], target_r[kind_idx]})
                  - $signed({tag_q_r.value[31], tag_q_r.value});
  assign mag_nxt  = diff[32] ? 33'(-diff) : 33'(diff);

  // Stage 2: magnitude times weight; a magnitude of exactly 2^32 is a shift
  assign prod_nxt = mag_r[32] ? {wgt_r, 32'd0} : 64'(mag_r[31:0]) * 64'(wgt_r);

  // Stage 3: saturating accumulate of the Q48.16 term
  assign sum_add  = {1'b0, sum_r} + {17'd0, prod_r[63:16]};

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    wgt_r  <= weight_r[kind_idx];
    prod_r <= prod_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wtbm_pkg::ST_IDLE:  if (accept && in_mode == wtbm_pkg::MODE_QUERY) state_nxt = wtbm_pkg::ST_AREQ;
      wtbm_pkg::ST_AREQ:  state_nxt = (a_r < aend_r) ? wtbm_pkg::ST_AWAIT : wtbm_pkg::ST_FIN;
      wtbm_pkg::ST_AWAIT: state_nxt = wtbm_pkg::ST_TWALK;
      wtbm_pkg::ST_TWALK: if (walk_done) state_nxt = wtbm_pkg::ST_CMP;
      wtbm_pkg::ST_CMP:   state_nxt = wtbm_pkg::ST_AREQ;
      wtbm_pkg::ST_FIN:   if (out_free) state_nxt = wtbm_pkg::ST_IDLE;
      default:            state_nxt = wtbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wtbm_pkg::ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < wtbm_pkg::TYPE_COUNT; i++) begin
        type_first_r[i] <= '0;
        type_end_r[i]   <= '0;
      end
      for (int k = 0; k < wtbm_pkg::TAG_KINDS; k++) begin
        target_r[k] <= '0;
        weight_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r && kind_ok;
      v3_r    <= v2_r;

      if (accept && in_mode == wtbm_pkg::MODE_TYPE &&
          32'(in_type_id) < wtbm_pkg::TYPE_COUNT) begin
        type_first_r[in_type_id[YW-1:0]] <= in_first_asset;
        type_end_r[in_type_id[YW-1:0]]   <= in_end_asset;
      end
      if (accept && in_mode == wtbm_pkg::MODE_VECTOR &&
          32'(in_tag_kind) < wtbm_pkg::TAG_KINDS) begin
        target_r[in_tag_kind[KW-1:0]] <= in_value;
        weight_r[in_tag_kind[KW-1:0]] <= in_weight;
      end

      if (accept && in_mode == wtbm_pkg::MODE_QUERY) begin
        have_r <= 1'b0;
        if (32'(in_type_id) < wtbm_pkg::TYPE_COUNT) begin
          a_r    <= type_first_r[in_type_id[YW-1:0]];
          aend_r <= (32'(type_end_r[in_type_id[YW-1:0]]) > wtbm_pkg::ASSET_DEPTH) ?
                    11'(wtbm_pkg::ASSET_DEPTH) : type_end_r[in_type_id[YW-1:0]];
        end else begin
          a_r    <= '0;
          aend_r <= '0;
        end
      end

      if (state_r == wtbm_pkg::ST_AWAIT) begin
        t_r        <= asset_q_r.first_tag;
        tend_r     <= (32'(asset_q_r.end_tag) > wtbm_pkg::TAG_DEPTH) ?
                      13'(wtbm_pkg::TAG_DEPTH) : asset_q_r.end_tag;
        cur_slot_r <= asset_q_r.slot;
        sum_r      <= '0;
      end
      if (issue) t_r <= t_r + 13'd1;
      if (v3_r) sum_r <= sum_add[64] ? '1 : sum_add[63:0];

      if (state_r == wtbm_pkg::ST_CMP) begin
        // keep the first entry on ties
        if (!have_r || sum_r < best_r) begin
          best_r      <= sum_r;
          best_slot_r <= cur_slot_r;
          have_r      <= 1'b1;
        end
        a_r <= a_r + 11'd1;
      end

      if (state_r == wtbm_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        out_found_r <= have_r;
        out_slot_r  <= have_r ? best_slot_r : 12'd0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_slot = out_slot_r;
  assign out_found     = out_found_r;

endmodule

// File: rtl/wtbm_checker.sv
// Port-level checks for the best-match block, bound to the top level
`include "weighted_tag_best_match_assert.svh"

module wtbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_best_slot,
  input logic        out_found
);

  `WTBM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `WTBM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_best_slot) && $stable(out_found))
  `WTBM_ASSERT_NOW(a_empty_slot, clk, rst_n, out_valid && !out_found, out_best_slot == 12'd0)
  `WTBM_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && in_mode == wtbm_pkg::MODE_QUERY, in_stall)

endmodule

bind weighted_tag_best_match wtbm_checker u_wtbm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_best_slot (out_best_slot),
  .out_found     (out_found)
);
